// ----- design/cwmw_pkg.sv -----
`default_nettype none
package cwmw_pkg;

   localparam int COORD_BITS    = 12;
   localparam int SINE_ENTRIES  = 1024;
   localparam int HP_BITS       = 20;
   localparam int OUT_BITS      = 14;
   localparam int FRAC_BITS     = 16;

   localparam int L2_BITS       = 2 * COORD_BITS + 1;
   localparam int RAD_BITS      = 2 * COORD_BITS + 18;
   localparam int ROOT_BITS     = RAD_BITS / 2;
   localparam int DIVD_BITS     = ROOT_BITS + FRAC_BITS;
   localparam int PHASE_BITS    = FRAC_BITS + 1;
   localparam int SINE_IDX_BITS = $clog2(SINE_ENTRIES) + 1;
   localparam int SINE_SHIFT    = FRAC_BITS - $clog2(SINE_ENTRIES);
   localparam int SINE_BITS     = FRAC_BITS + 1;
   localparam int DIFF_BITS     = FRAC_BITS + 2;
   localparam int PROD_BITS     = DIFF_BITS + HP_BITS + 1;
   localparam int DEN_BITS      = ROOT_BITS + FRAC_BITS;
   localparam int NUM_BITS      = ((DEN_BITS > PROD_BITS) ? DEN_BITS : PROD_BITS) + 1;
   localparam int MAG_BITS      = NUM_BITS - 1;
   localparam int SPLIT_BITS    = MAG_BITS / 2;
   localparam int HI_BITS       = MAG_BITS - SPLIT_BITS;
   localparam int P_BITS        = COORD_BITS + MAG_BITS;
   localparam int Q_BITS        = OUT_BITS + 1;
   localparam int DIV_BITS      = (P_BITS > DEN_BITS + Q_BITS) ? P_BITS : DEN_BITS + Q_BITS;
   localparam int SUM_BITS      = Q_BITS + 2;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [HP_BITS-1:0]   HP_RESET = HP_BITS'(8192);
   localparam logic [SINE_BITS-1:0] ONE_Q16  = SINE_BITS'(1) << FRAC_BITS;
   localparam logic [DEN_BITS-1:0]  DEN_MIN  = DEN_BITS'(1) << (FRAC_BITS + 8);
   localparam logic [OUT_BITS-1:0]  OUT_MAX  = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0]  OUT_MIN  = {1'b1, {(OUT_BITS-1){1'b0}}};

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ONE_Q30     = 64'd1 << 30;

   typedef enum logic [1:0] {
      PLACE_INTERIOR = 2'd0,
      PLACE_LR_EDGE  = 2'd1,
      PLACE_TB_EDGE  = 2'd2,
      PLACE_CORNER   = 2'd3
   } place_type;

   typedef enum logic [1:0] {
      CSR_SOURCE_X     = 2'd0,
      CSR_SOURCE_Y     = 2'd1,
      CSR_HALF_PERIOD  = 2'd2,
      CSR_BORDER_SHIFT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                  valid;
      logic [COORD_BITS-1:0] nx;
      logic [COORD_BITS-1:0] ny;
      place_type             place;
   } ctl_type;

   typedef logic [SINE_BITS-1:0] sine_rom_type [SINE_ENTRIES+1];

   // quarter-wave table, Q16, Taylor series in Q30
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type    rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned t;
      longint unsigned s;
      for (int k = 0; k <= SINE_ENTRIES; k++) begin
         x  = (HALF_PI_Q30 * longint'(k)) / SINE_ENTRIES;
         x2 = (x * x) >> 30;
         t  = ONE_Q30 - x2 / 110;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
         t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
         s  = (x * t) >> 30;
         s  = (s + 64'd8192) >> 14;
         if (s > 64'd65536) begin
            s = 64'd65536;
         end
         rom[k] = SINE_BITS'(s);
      end
      return rom;
   endfunction

endpackage
`default_nettype wire

// ----- design/cwmw_req_if.sv -----
`default_nettype none
interface cwmw_req_if
   import cwmw_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] node_x;
   logic [COORD_BITS-1:0] node_y;
   logic [1:0]            node_place;

   modport source (output valid, output node_x, output node_y, output node_place, input ready);
   modport sink   (input valid, input node_x, input node_y, input node_place, output ready);
endinterface
`default_nettype wire

// ----- design/cwmw_rsp_if.sv -----
`default_nettype none
interface cwmw_rsp_if
   import cwmw_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [OUT_BITS-1:0] moved_x;
   logic signed [OUT_BITS-1:0] moved_y;

   modport source (output valid, output moved_x, output moved_y, input ready);
   modport sink   (input valid, input moved_x, input moved_y, output ready);
endinterface
`default_nettype wire

// ----- design/cwmw_sqrt.sv -----
`default_nettype none
module cwmw_sqrt
   import cwmw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  ctl_type               ctl_in,
   input  logic [COORD_BITS-1:0] src_x,
   input  logic [COORD_BITS-1:0] src_y,
   output ctl_type               ctl_out,
   output logic [ROOT_BITS-1:0]  root
);

   ctl_type                    ctl_ff [ROOT_BITS+1];
   logic [RAD_BITS-1:0]        v_ff   [ROOT_BITS+1];
   logic [RAD_BITS-1:0]        res_ff [ROOT_BITS+1];
   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic [L2_BITS-1:0]         l2;

   assign dx = signed'({1'b0, ctl_in.nx}) - signed'({1'b0, src_x});
   assign dy = signed'({1'b0, ctl_in.ny}) - signed'({1'b0, src_y});
   assign l2 = L2_BITS'(unsigned'((2*COORD_BITS)'(dx * dx)))
             + L2_BITS'(unsigned'((2*COORD_BITS)'(dy * dy)));

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         v_ff[0]   <= RAD_BITS'({l2, {FRAC_BITS{1'b0}}});
         res_ff[0] <= '0;
      end
   end

   // one root bit per stage
   for (genvar i = 0; i < ROOT_BITS; i++) begin : g_step
      localparam logic [RAD_BITS-1:0] STEP = RAD_BITS'(1) << (2 * (ROOT_BITS - 1 - i));
      logic [RAD_BITS:0] trial;

      assign trial = {1'b0, res_ff[i]} + {1'b0, STEP};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i+1].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[i+1] <= ctl_ff[i];
            if ({1'b0, v_ff[i]} >= trial) begin
               v_ff[i+1]   <= v_ff[i] - trial[RAD_BITS-1:0];
               res_ff[i+1] <= (res_ff[i] >> 1) + STEP;
            end else begin
               v_ff[i+1]   <= v_ff[i];
               res_ff[i+1] <= res_ff[i] >> 1;
            end
         end
      end
   end

   assign ctl_out = ctl_ff[ROOT_BITS];
   assign root    = res_ff[ROOT_BITS][ROOT_BITS-1:0];

endmodule
`default_nettype wire

// ----- design/cwmw_phase.sv -----
`default_nettype none
module cwmw_phase
   import cwmw_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  ctl_type                ctl_in,
   input  logic [ROOT_BITS-1:0]   root_in,
   input  logic [HP_BITS-1:0]     hq,
   output ctl_type                ctl_out,
   output logic [ROOT_BITS-1:0]   root_out,
   output logic [PHASE_BITS-1:0]  phase
);

   ctl_type                 ctl_ff  [DIVD_BITS+1];
   logic [ROOT_BITS-1:0]    root_ff [DIVD_BITS+1];
   logic [HP_BITS-1:0]      rem_ff  [DIVD_BITS+1];
   logic [PHASE_BITS-1:0]   q_ff    [DIVD_BITS+1];

   assign ctl_ff[0]  = ctl_in;
   assign root_ff[0] = root_in;
   assign rem_ff[0]  = '0;
   assign q_ff[0]    = '0;

   // restoring divide of root*2^16 by hq, one quotient bit per stage;
   // only the low quotient bits are kept
   for (genvar i = 0; i < DIVD_BITS; i++) begin : g_step
      localparam int J = DIVD_BITS - 1 - i;
      logic             b;
      logic [HP_BITS:0] sh;
      logic             take;

      if (J >= FRAC_BITS) begin : g_root
         assign b = root_ff[i][J-FRAC_BITS];
      end else begin : g_zero
         assign b = 1'b0;
      end

      assign sh   = {rem_ff[i], b};
      assign take = sh >= {1'b0, hq};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i+1].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[i+1]  <= ctl_ff[i];
            root_ff[i+1] <= root_ff[i];
            rem_ff[i+1]  <= take ? HP_BITS'(sh - {1'b0, hq}) : sh[HP_BITS-1:0];
            q_ff[i+1]    <= {q_ff[i][PHASE_BITS-2:0], take};
         end
      end
   end

   assign ctl_out  = ctl_ff[DIVD_BITS];
   assign root_out = root_ff[DIVD_BITS];
   assign phase    = q_ff[DIVD_BITS];

endmodule
`default_nettype wire

// ----- design/cwmw_gain.sv -----
`default_nettype none
module cwmw_gain
   import cwmw_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  ctl_type                     ctl_in,
   input  logic [ROOT_BITS-1:0]        root_in,
   input  logic [PHASE_BITS-1:0]       phase,
   input  logic [HP_BITS-1:0]          hq,
   output ctl_type                     ctl_out,
   output logic signed [NUM_BITS-1:0]  num,
   output logic [DEN_BITS-1:0]         den
);

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   ctl_type                     ctl1_ff;
   ctl_type                     ctl2_ff;
   ctl_type                     ctl3_ff;
   logic [ROOT_BITS-1:0]        root1_ff;
   logic [ROOT_BITS-1:0]        root2_ff;
   logic [FRAC_BITS-1:0]        r_ff;
   logic                        half_ff;
   logic [SINE_BITS-1:0]        sine_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [NUM_BITS-1:0]  num_ff;
   logic [DEN_BITS-1:0]         den_ff;

   logic [SINE_BITS-1:0]        arg;
   logic [SINE_IDX_BITS-1:0]    idx;
   logic [SINE_BITS-1:0]        w;
   logic signed [DIFF_BITS-1:0] diff;
   logic signed [PROD_BITS-1:0] prod;
   logic [DEN_BITS-1:0]         den_c;

   assign arg   = phase[FRAC_BITS] ? ONE_Q16 - {1'b0, phase[FRAC_BITS-1:0]}
                                   : {1'b0, phase[FRAC_BITS-1:0]};
   assign idx   = SINE_IDX_BITS'(arg >> SINE_SHIFT);
   assign w     = half_ff ? ONE_Q16 - sine_ff : sine_ff;
   assign diff  = signed'(DIFF_BITS'(w)) - signed'(DIFF_BITS'(r_ff));
   assign prod  = PROD_BITS'(diff * signed'({1'b0, hq}));
   assign den_c = {root2_ff, {FRAC_BITS{1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
      end else if (en) begin
         ctl1_ff  <= ctl_in;
         root1_ff <= root_in;
         r_ff     <= phase[FRAC_BITS-1:0];
         half_ff  <= phase[FRAC_BITS];
         sine_ff  <= SINE_ROM[idx];
         ctl2_ff  <= ctl1_ff;
         root2_ff <= root1_ff;
         prod_ff  <= prod;
         ctl3_ff  <= ctl2_ff;
         den_ff   <= den_c;
         num_ff   <= signed'(NUM_BITS'(den_c)) + NUM_BITS'(prod_ff);
      end
   end

   assign ctl_out = ctl3_ff;
   assign num     = num_ff;
   assign den     = den_ff;

endmodule
`default_nettype wire

// ----- design/cwmw_scale.sv -----
`default_nettype none
module cwmw_scale
   import cwmw_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  ctl_type                    ctl_in,
   input  logic signed [NUM_BITS-1:0] num,
   input  logic [DEN_BITS-1:0]        den,
   input  logic [COORD_BITS-1:0]      src_x,
   input  logic [COORD_BITS-1:0]      src_y,
   input  logic                       shift_en,
   output logic                       out_valid,
   output logic [OUT_BITS-1:0]        moved_x,
   output logic [OUT_BITS-1:0]        moved_y
);

   // abs, partial products, sum, range check, Q_BITS divide steps, output
   localparam int NS = Q_BITS + 5;

   ctl_type               ctl_ff [NS];
   logic [DEN_BITS-1:0]   den_ff [Q_BITS+3];
   logic [MAG_BITS-1:0]   nmag_ff;
   logic [MAG_BITS-1:0]   nmag;
   logic [OUT_BITS-1:0]   moved [2];
   logic                  at_src;

   assign nmag   = MAG_BITS'(num[NUM_BITS-1] ? -num : num);
   assign at_src = (ctl_ff[NS-2].nx == src_x) && (ctl_ff[NS-2].ny == src_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else if (en) begin
         ctl_ff[0] <= ctl_in;
         den_ff[0] <= den;
         nmag_ff   <= nmag;
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_ctl
      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[s] <= ctl_ff[s-1];
         end
      end
      if (s < Q_BITS + 3) begin : g_den
         always_ff @(posedge clock) begin
            if (en) begin
               den_ff[s] <= den_ff[s-1];
            end
         end
      end
   end

   for (genvar lane = 0; lane < 2; lane++) begin : g_lane
      logic [COORD_BITS-1:0]         c_in;
      logic [COORD_BITS-1:0]         c_fin;
      logic [COORD_BITS-1:0]         src;
      place_type                     edge_place;
      logic signed [COORD_BITS:0]    d;
      logic                          neg_ff  [NS-1];
      logic [COORD_BITS-1:0]         mag_ff;
      logic [COORD_BITS+SPLIT_BITS-1:0] lo_ff;
      logic [COORD_BITS+HI_BITS-1:0] hi_ff;
      logic [P_BITS-1:0]             p_ff;
      logic [DIV_BITS-1:0]           rem_ff  [Q_BITS+1];
      logic [Q_BITS-1:0]             q_ff    [Q_BITS+1];
      logic                          ovf_ff  [Q_BITS+1];
      logic signed [Q_BITS:0]        qs;
      logic signed [SUM_BITS-1:0]    sum;
      logic [OUT_BITS-1:0]           warped;
      logic                          use_warp;
      logic [OUT_BITS-1:0]           moved_ff;

      if (lane == 0) begin : g_x
         assign c_in       = ctl_in.nx;
         assign c_fin      = ctl_ff[NS-2].nx;
         assign src        = src_x;
         assign edge_place = PLACE_TB_EDGE;
      end else begin : g_y
         assign c_in       = ctl_in.ny;
         assign c_fin      = ctl_ff[NS-2].ny;
         assign src        = src_y;
         assign edge_place = PLACE_LR_EDGE;
      end

      assign d = signed'({1'b0, c_in}) - signed'({1'b0, src});

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[0] <= d[COORD_BITS] ^ num[NUM_BITS-1];
            mag_ff    <= COORD_BITS'(d[COORD_BITS] ? -d : d);
            lo_ff     <= mag_ff * nmag_ff[SPLIT_BITS-1:0];
            hi_ff     <= mag_ff * nmag_ff[MAG_BITS-1:SPLIT_BITS];
            p_ff      <= (P_BITS'(hi_ff) << SPLIT_BITS) + P_BITS'(lo_ff);
            rem_ff[0] <= DIV_BITS'(p_ff);
            ovf_ff[0] <= DIV_BITS'(p_ff) >= (DIV_BITS'(den_ff[2]) << Q_BITS);
            q_ff[0]   <= '0;
         end
      end

      for (genvar s = 1; s < NS - 1; s++) begin : g_neg
         always_ff @(posedge clock) begin
            if (en) begin
               neg_ff[s] <= neg_ff[s-1];
            end
         end
      end

      for (genvar k = 1; k <= Q_BITS; k++) begin : g_div
         logic [DIV_BITS-1:0] dsh;
         logic                take;

         assign dsh  = DIV_BITS'(den_ff[k+2]) << (Q_BITS - k);
         assign take = rem_ff[k-1] >= dsh;

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= take ? rem_ff[k-1] - dsh : rem_ff[k-1];
               q_ff[k]   <= {q_ff[k-1][Q_BITS-2:0], take};
               ovf_ff[k] <= ovf_ff[k-1];
            end
         end
      end

      assign qs  = neg_ff[NS-2] ? -signed'({1'b0, q_ff[Q_BITS]}) : signed'({1'b0, q_ff[Q_BITS]});
      assign sum = signed'(SUM_BITS'(src)) + SUM_BITS'(qs);

      always_comb begin
         if (at_src) begin
            warped = OUT_BITS'(c_fin);
         end else if (ovf_ff[Q_BITS]) begin
            warped = neg_ff[NS-2] ? OUT_MIN : OUT_MAX;
         end else if ((sum[SUM_BITS-1:OUT_BITS-1] == '0)
                      || (sum[SUM_BITS-1:OUT_BITS-1] == '1)) begin
            warped = sum[OUT_BITS-1:0];
         end else begin
            warped = sum[SUM_BITS-1] ? OUT_MIN : OUT_MAX;
         end
      end

      assign use_warp = (ctl_ff[NS-2].place == PLACE_INTERIOR)
                        || ((ctl_ff[NS-2].place == edge_place) && shift_en);

      always_ff @(posedge clock) begin
         if (en) begin
            moved_ff <= use_warp ? warped : OUT_BITS'(c_fin);
         end
      end

      assign moved[lane] = moved_ff;
   end

   assign out_valid = ctl_ff[NS-1].valid;
   assign moved_x   = moved[0];
   assign moved_y   = moved[1];

endmodule
`default_nettype wire

// ----- design/concentric_wave_mesh_warp_core.sv -----
`default_nettype none
// Path: an accepted req word passes the root, phase divide, sine/gain and scale
// divide stages and the output register before it leaves as its rsp word.
// Throughput: one word per cycle; a stalled rsp holds the whole pipeline.
// Reset (synchronous): all pipeline valids clear, registers return to source 0,0,
// half period 32.0 pixels, border shifting off.
module concentric_wave_mesh_warp_core
   import cwmw_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   cwmw_req_if.sink                 req,
   cwmw_rsp_if.source               rsp,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [COORD_BITS-1:0] src_x_ff;
   logic [COORD_BITS-1:0] src_y_ff;
   logic [HP_BITS-1:0]    hp_ff;
   logic                  shift_ff;
   logic [HP_BITS-1:0]    hq;
   logic                  csr_wr;
   csr_index_type         csr_idx;
   logic                  en;

   ctl_type                     ctl_in;
   ctl_type                     sqrt_ctl;
   ctl_type                     phase_ctl;
   ctl_type                     gain_ctl;
   logic [ROOT_BITS-1:0]        sqrt_root;
   logic [ROOT_BITS-1:0]        phase_root;
   logic [PHASE_BITS-1:0]       phase;
   logic signed [NUM_BITS-1:0]  gain_num;
   logic [DEN_BITS-1:0]         gain_den;
   logic                        out_valid;
   logic [OUT_BITS-1:0]         moved_x;
   logic [OUT_BITS-1:0]         moved_y;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         src_x_ff <= '0;
         src_y_ff <= '0;
         hp_ff    <= HP_RESET;
         shift_ff <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            CSR_SOURCE_X:     src_x_ff <= csr_pwdata[COORD_BITS-1:0];
            CSR_SOURCE_Y:     src_y_ff <= csr_pwdata[COORD_BITS-1:0];
            CSR_HALF_PERIOD:  hp_ff    <= csr_pwdata[HP_BITS-1:0];
            CSR_BORDER_SHIFT: shift_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_SOURCE_X:     csr_prdata = CSR_DATA_BITS'(src_x_ff);
         CSR_SOURCE_Y:     csr_prdata = CSR_DATA_BITS'(src_y_ff);
         CSR_HALF_PERIOD:  csr_prdata = CSR_DATA_BITS'(hp_ff);
         CSR_BORDER_SHIFT: csr_prdata = CSR_DATA_BITS'(shift_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // zero half period acts as one
   assign hq = (hp_ff == '0) ? HP_BITS'(1) : hp_ff;

   assign en        = !out_valid || rsp.ready;
   assign req.ready = en;

   assign ctl_in.valid = req.valid;
   assign ctl_in.nx    = req.node_x;
   assign ctl_in.ny    = req.node_y;
   assign ctl_in.place = place_type'(req.node_place);

   cwmw_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (ctl_in),
      .src_x   (src_x_ff),
      .src_y   (src_y_ff),
      .ctl_out (sqrt_ctl),
      .root    (sqrt_root)
   );

   cwmw_phase u_phase (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .ctl_in   (sqrt_ctl),
      .root_in  (sqrt_root),
      .hq       (hq),
      .ctl_out  (phase_ctl),
      .root_out (phase_root),
      .phase    (phase)
   );

   cwmw_gain u_gain (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (phase_ctl),
      .root_in (phase_root),
      .phase   (phase),
      .hq      (hq),
      .ctl_out (gain_ctl),
      .num     (gain_num),
      .den     (gain_den)
   );

   cwmw_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .ctl_in    (gain_ctl),
      .num       (gain_num),
      .den       (gain_den),
      .src_x     (src_x_ff),
      .src_y     (src_y_ff),
      .shift_en  (shift_ff),
      .out_valid (out_valid),
      .moved_x   (moved_x),
      .moved_y   (moved_y)
   );

   assign rsp.valid   = out_valid;
   assign rsp.moved_x = signed'(moved_x);
   assign rsp.moved_y = signed'(moved_y);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp.valid)
      else $error("rsp word present right after reset");

   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(sqrt_ctl.valid) && $stable(phase_ctl.valid) && $stable(gain_ctl.valid))
      else $error("pipeline moved during stall");

   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      gain_ctl.valid && (gain_ctl.nx != src_x_ff || gain_ctl.ny != src_y_ff)
      |-> gain_den >= DEN_MIN)
      else $error("distance below one pixel for a node off the source");

endmodule
`default_nettype wire
